FILE: rtl/assert_macros.svh
// assertion macros shared by the inversion counter rtl
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every cycle outside reset
`define IC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ic_pkg.sv
// ic_pkg: shared types and constants of the inversion counter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ic_pkg;

  localparam int unsigned MaxItemsDefault = 1024;
  localparam int unsigned ValueW          = 32;
  localparam int unsigned CountW          = 19;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [CountW-1:0]        count_t;

  localparam count_t CountMax = '1;

  // top level to merge sequencer
  typedef struct packed {
    logic start;
    logic ack;
  } ic_ctl_t;

  // merge sequencer to top level
  typedef struct packed {
    logic busy;
    logic done;
  } ic_sts_t;

endpackage

`default_nettype wire

FILE: rtl/ic_if.sv
// ic_in_if / ic_out_if: valid-ready channels of the inversion counter
// depends on ic_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ic_in_if import ic_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   last;

  modport source (output valid, value, last, input ready);
  modport sink (input valid, value, last, output ready);
endinterface

interface ic_out_if import ic_pkg::*; ();
  logic   valid;
  logic   ready;
  count_t inversion_count;
  logic   overflow;

  modport source (output valid, inversion_count, overflow, input ready);
  modport sink (input valid, inversion_count, overflow, output ready);
endinterface

`default_nettype wire

FILE: rtl/ic_ram.sv
// ic_ram: generic ram, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ic_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: rtl/ic_merge.sv
// ic_merge: bottom-up merge sort sequencer with one shared compare/count unit
// depends on ic_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module ic_merge import ic_pkg::*; #(
  parameter int unsigned MaxItems = MaxItemsDefault,
  localparam int unsigned AddrW = $clog2(MaxItems),
  localparam int unsigned NumW  = AddrW + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ic_ctl_t          ctl_i,
  input  wire logic [NumW-1:0]  n_i,
  output ic_sts_t               sts_o,
  output count_t                count_o,
  output logic                  src_o,
  output logic      [AddrW-1:0] rd_addr_a_o,
  output logic      [AddrW-1:0] rd_addr_b_o,
  input  wire value_t           rd_data_a_i,
  input  wire value_t           rd_data_b_i,
  output logic                  wr_en_o,
  output logic      [AddrW-1:0] wr_addr_o,
  output value_t                wr_data_o
);

  localparam int unsigned SumW = ((NumW > CountW) ? NumW : CountW) + 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MID  = 6'b000010,
    ST_HI   = 6'b000100,
    ST_RD   = 6'b001000,
    ST_CMP  = 6'b010000,
    ST_DONE = 6'b100000
  } ic_state_e;

  ic_state_e       state_q, state_d;
  logic [NumW-1:0] n_q, n_d;
  logic [NumW-1:0] width_q, width_d;
  logic [NumW-1:0] lo_q, lo_d;
  logic [NumW-1:0] mid_q, mid_d;
  logic [NumW-1:0] hi_q, hi_d;
  logic [NumW-1:0] a_q, a_d;
  logic [NumW-1:0] b_q, b_d;
  logic [NumW-1:0] k_q, k_d;
  logic [NumW-1:0] rem_q, rem_d;
  logic            src_q, src_d;
  count_t          cnt_q, cnt_d;

  logic [NumW-1:0] span_base;
  logic [NumW-1:0] span_end;
  logic [NumW-1:0] width_dbl;
  logic [NumW-1:0] k_inc;
  logic [SumW-1:0] sum_w;
  count_t          cnt_sat;
  logic            take_a;

  // shared run-boundary unit: base + width clipped to n
  assign span_base = (state_q == ST_MID) ? lo_q : mid_q;
  assign span_end  = ((n_q - span_base) > width_q) ? (span_base + width_q) : n_q;
  assign width_dbl = {width_q[NumW-2:0], 1'b0};
  assign k_inc     = k_q + NumW'(1);

  // left run still waiting is counted when the right head goes first
  assign sum_w   = SumW'(cnt_q) + SumW'(rem_q);
  assign cnt_sat = (sum_w > SumW'(CountMax)) ? CountMax : sum_w[CountW-1:0];
  assign take_a  = (rem_q != '0) && ((b_q == hi_q) || (rd_data_a_i <= rd_data_b_i));

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    width_d = width_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    rem_d   = rem_q;
    src_d   = src_q;
    cnt_d   = cnt_q;
    wr_en_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (ctl_i.start) begin
          n_d     = n_i;
          cnt_d   = '0;
          src_d   = 1'b0;
          width_d = NumW'(1);
          lo_d    = '0;
          state_d = (n_i <= NumW'(1)) ? ST_DONE : ST_MID;
        end
      end
      ST_MID: begin
        mid_d   = span_end;
        a_d     = lo_q;
        k_d     = lo_q;
        state_d = ST_HI;
      end
      ST_HI: begin
        hi_d    = span_end;
        b_d     = mid_q;
        rem_d   = mid_q - lo_q;
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        wr_en_o = 1'b1;
        k_d     = k_inc;
        if (take_a) begin
          a_d   = a_q + NumW'(1);
          rem_d = rem_q - NumW'(1);
        end else begin
          b_d   = b_q + NumW'(1);
          cnt_d = cnt_sat;
        end
        if (k_inc == hi_q) begin
          lo_d    = hi_q;
          state_d = ST_MID;
          if (hi_q == n_q) begin
            // pass complete: swap banks and double the run length
            src_d   = ~src_q;
            width_d = width_dbl;
            lo_d    = '0;
            state_d = (width_dbl >= n_q) ? ST_DONE : ST_MID;
          end
        end else begin
          state_d = ST_RD;
        end
      end
      ST_DONE: begin
        if (ctl_i.ack) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      width_q <= '0;
      lo_q    <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      a_q     <= '0;
      b_q     <= '0;
      k_q     <= '0;
      rem_q   <= '0;
      src_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      width_q <= width_d;
      lo_q    <= lo_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      a_q     <= a_d;
      b_q     <= b_d;
      k_q     <= k_d;
      rem_q   <= rem_d;
      src_q   <= src_d;
      cnt_q   <= cnt_d;
    end
  end

  assign sts_o.busy  = (state_q != ST_IDLE);
  assign sts_o.done  = (state_q == ST_DONE);
  assign count_o     = cnt_q;
  assign src_o       = src_q;
  assign rd_addr_a_o = a_q[AddrW-1:0];
  assign rd_addr_b_o = b_q[AddrW-1:0];
  assign wr_addr_o   = k_q[AddrW-1:0];
  assign wr_data_o   = take_a ? rd_data_a_i : rd_data_b_i;

  `include "assert_macros.svh"

  `IC_ASSERT(a_write_in_run, (state_q == ST_CMP) |-> (k_q < hi_q), "merge write beyond run end")
  `IC_ASSERT(a_left_remaining, (state_q == ST_CMP) |-> (rem_q == (mid_q - a_q)), "left count out of step")

endmodule

`default_nettype wire

FILE: rtl/inversion_counter_core.sv
// inversion_counter_core: counts inversions of a signed sequence by merge sort
// depends on ic_pkg, ic_if, ic_ram, ic_merge and assert_macros.svh
//
//  channel | dir | payload                     | transfer
//  in_i    | in  | value[31:0] signed, last    | valid & ready
//  out_o   | out | inversion_count[18:0], ovf  | valid & ready
//
// loading takes one cycle per element; ready drops from the last transfer
// until the result is handed to the output register
// the merge sequencer opens each run in ST_MID and ST_HI, then reads and
// compares each element in ST_RD and ST_CMP, on every pass; one compare/count
// unit and the two read ports of the current source bank set its pace
// reset clears control state only; both banks need no clearing pass
// a pending result on out_o holds without blocking the next sequence load
`timescale 1ns / 1ps
`default_nettype none

module inversion_counter_core import ic_pkg::*; #(
  parameter int unsigned MaxItems = MaxItemsDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  ic_in_if.sink    in_i,
  ic_out_if.source out_o
);

  localparam int unsigned AddrW = $clog2(MaxItems);
  localparam int unsigned NumW  = AddrW + 1;

  logic [NumW-1:0]  cnt_q, cnt_d;
  logic             dropped_q, dropped_d;
  logic             ovf_q;
  logic             out_valid_q;
  count_t           out_count_q;
  logic             out_ovf_q;

  logic             accept;
  logic             room;
  logic             load_we;

  ic_ctl_t          merge_ctl;
  ic_sts_t          merge_sts;
  logic [NumW-1:0]  merge_n;
  count_t           merge_count;
  logic             src_b;
  logic [AddrW-1:0] rd_addr_a, rd_addr_b;
  value_t           rd_data_a, rd_data_b;
  logic             m_wr_en;
  logic [AddrW-1:0] m_wr_addr;
  value_t           m_wr_data;

  logic             bank_a_we, bank_b_we;
  logic [AddrW-1:0] bank_a_waddr;
  value_t           bank_a_wdata;
  value_t           a_rd_a, a_rd_b, b_rd_a, b_rd_b;

  assign in_i.ready = ~merge_sts.busy;
  assign accept     = in_i.valid & in_i.ready;
  assign room       = (cnt_q < NumW'(MaxItems));
  assign load_we    = accept & room;

  always_comb begin
    cnt_d     = cnt_q;
    dropped_d = dropped_q;
    if (accept) begin
      if (in_i.last) begin
        cnt_d     = '0;
        dropped_d = 1'b0;
      end else if (room) begin
        cnt_d = cnt_q + NumW'(1);
      end else begin
        dropped_d = 1'b1;
      end
    end
  end

  assign merge_ctl.start = accept & in_i.last;
  assign merge_ctl.ack   = merge_sts.done & (~out_valid_q | out_o.ready);
  assign merge_n         = room ? (cnt_q + NumW'(1)) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      dropped_q   <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      dropped_q <= dropped_d;
      if (merge_ctl.start) begin
        ovf_q <= dropped_q | ~room;
      end
      if (merge_ctl.ack) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge_ctl.ack) begin
      out_count_q <= merge_count;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.inversion_count = out_count_q;
  assign out_o.overflow        = out_ovf_q;

  // bank a takes the loaded elements, then both banks alternate as merge target
  assign bank_a_we    = load_we | (m_wr_en & src_b);
  assign bank_b_we    = m_wr_en & ~src_b;
  assign bank_a_waddr = load_we ? cnt_q[AddrW-1:0] : m_wr_addr;
  assign bank_a_wdata = load_we ? in_i.value : m_wr_data;

  ic_ram #(
    .Width (ValueW),
    .Depth (MaxItems)
  ) u_bank_a (
    .clk_i     (clk_i),
    .we_i      (bank_a_we),
    .waddr_i   (bank_a_waddr),
    .wdata_i   (bank_a_wdata),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (a_rd_a),
    .rdata_b_o (a_rd_b)
  );

  ic_ram #(
    .Width (ValueW),
    .Depth (MaxItems)
  ) u_bank_b (
    .clk_i     (clk_i),
    .we_i      (bank_b_we),
    .waddr_i   (m_wr_addr),
    .wdata_i   (m_wr_data),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (b_rd_a),
    .rdata_b_o (b_rd_b)
  );

  assign rd_data_a = src_b ? b_rd_a : a_rd_a;
  assign rd_data_b = src_b ? b_rd_b : a_rd_b;

  ic_merge #(
    .MaxItems (MaxItems)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (merge_ctl),
    .n_i         (merge_n),
    .sts_o       (merge_sts),
    .count_o     (merge_count),
    .src_o       (src_b),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b),
    .wr_en_o     (m_wr_en),
    .wr_addr_o   (m_wr_addr),
    .wr_data_o   (m_wr_data)
  );

  `include "assert_macros.svh"

  `IC_ASSERT(a_drop_when_full, dropped_q |-> (cnt_q == NumW'(MaxItems)), "drop flag set below capacity")
  `IC_ASSERT(a_count_bound, cnt_q <= NumW'(MaxItems), "element count past capacity")
  `IC_ASSERT_NEXT(a_result_loaded, merge_ctl.ack, out_valid_q, "result not held after merge")

endmodule

`default_nettype wire

FILE: tb/inversion_counter_core_tb.sv
// inversion_counter_core_tb: self-checking bench for the inversion counter core
// drives signed sequences through ic_in_if, checks counts from ic_out_if
// depends on ic_pkg, ic_if and inversion_counter_core
`timescale 1ns / 1ps

module inversion_counter_core_tb;
  import ic_pkg::*;

  localparam int unsigned MaxItems     = MaxItemsDefault;
  localparam int unsigned RandomItems  = 500;
  localparam int unsigned QuietTail    = 80;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned DrainCycles  = 300;
  localparam int unsigned HoldCycles   = 800;

  localparam value_t ValMin = 32'h8000_0000;
  localparam value_t ValMax = 32'h7fff_ffff;

  typedef value_t value_q_t[$];

  typedef struct {
    count_t inversion_count;
    logic   overflow;
  } tally_t;

  typedef enum int unsigned {
    PatRandom,
    PatNarrow,
    PatExtreme,
    PatFalling,
    PatRising
  } pattern_e;

  // keeps the current sequence and the counts still owed by the block
  class inversion_tally;
    value_t      held[$];
    bit          dropped;
    tally_t      awaited[$];
    int unsigned failures;
    int unsigned capacity;

    function new(int unsigned cap);
      capacity = cap;
      dropped  = 1'b0;
      failures = 0;
    endfunction

    function void report(string what);
      failures++;
      if (failures <= 10) $display("mismatch: %s", what);
    endfunction

    function void note_element(value_t v, logic l);
      tally_t          t;
      longint unsigned pairs;
      if (held.size() < capacity) held = {held, v};
      else dropped = 1'b1;
      if (l) begin
        pairs = 0;
        for (int i = 0; i < held.size(); i++)
          for (int j = i + 1; j < held.size(); j++)
            if (held[i] > held[j]) pairs++;
        t.inversion_count = (pairs > CountMax) ? CountMax : count_t'(pairs);
        t.overflow        = dropped;
        awaited = {awaited, t};
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_result(count_t c, logic o);
      tally_t t;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result count=%0d overflow=%0b", c, o));
        return;
      end
      t = awaited.pop_front();
      if (c !== t.inversion_count)
        report($sformatf("inversion_count expected %0d got %0d", t.inversion_count, c));
      if (o !== t.overflow)
        report($sformatf("overflow expected %0b got %0b", t.overflow, o));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ic_in_if  in_ch ();
  ic_out_if out_ch ();

  inversion_counter_core #(
    .MaxItems(MaxItems)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  inversion_tally tally;
  bit             gaps_on      = 1'b0;
  int unsigned    hold_request = 0;
  int unsigned    items_sent   = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // note every transfer on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready)
      tally.note_element(in_ch.value, in_ch.last);
    if (rst_ni && out_ch.valid && out_ch.ready)
      tally.check_result(out_ch.inversion_count, out_ch.overflow);
  end

  // result side: long hold-off on request, random stall bursts while gaps_on is set
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic idle_input(int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // returns right after the edge of the transfer
  task automatic send_element(value_t v, logic l);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= l;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_sequence(value_q_t seq);
    foreach (seq[i]) begin
      if (gaps_on && $urandom_range(0, 4) == 0) idle_input($urandom_range(1, 17));
      send_element(seq[i], i == seq.size() - 1);
    end
  endtask

  // checked at the falling edge so every transfer of the step is already noted
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (tally.pending() != 0);
    @(posedge clk_i);
  endtask

  function automatic value_q_t make_sequence(int unsigned len);
    value_q_t q;
    pattern_e pat;
    value_t   cur;
    value_t   nv;
    value_t   tmp;
    int       a;
    int       b;
    pat = pattern_e'($urandom_range(0, 4));
    cur = value_t'($urandom);
    for (int i = 0; i < len; i++) begin
      case (pat)
        PatRandom:  nv = value_t'($urandom);
        PatNarrow:  nv = value_t'(int'($urandom_range(0, 6)) - 3);
        PatExtreme: begin
          case ($urandom_range(0, 4))
            0:       nv = ValMin;
            1:       nv = ValMax;
            2:       nv = value_t'(-1);
            3:       nv = value_t'(0);
            default: nv = value_t'(1);
          endcase
        end
        PatFalling: begin
          cur = cur - value_t'($urandom_range(0, 2));
          nv  = cur;
        end
        default: begin
          cur = cur + value_t'($urandom_range(0, 2));
          nv  = cur;
        end
      endcase
      q = {q, nv};
    end
    // rising runs get two randomly picked elements swapped
    if (pat == PatRising && len > 1) begin
      a    = $urandom_range(0, len - 1);
      b    = $urandom_range(0, len - 1);
      tmp  = q[a];
      q[a] = q[b];
      q[b] = tmp;
    end
    return q;
  endfunction

  initial begin
    value_q_t    seq;
    int unsigned first_random;
    int unsigned len;
    int unsigned pick;
    tally = new(MaxItems);
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short sequences, extremes, equal values, fully reversed run
    gaps_on = 1'b0;
    seq = '{value_t'(0)};
    send_sequence(seq);
    seq = '{ValMin};
    send_sequence(seq);
    seq = '{ValMax, ValMin};
    send_sequence(seq);
    seq = '{ValMin, ValMax};
    send_sequence(seq);
    seq = '{value_t'(5), value_t'(5), value_t'(5)};
    send_sequence(seq);
    seq = '{value_t'(-1), value_t'(0), value_t'(1), value_t'(-1)};
    send_sequence(seq);
    seq = '{ValMax, value_t'(32'h4000_0000), value_t'(1), value_t'(0),
            value_t'(-1), ValMin};
    send_sequence(seq);

    // sender pauses until every count is back
    wait_results_drained();
    idle_input(SettleCycles);

    // result side holds off while sequences keep coming, so the core backs up
    hold_request = HoldCycles;
    for (int s = 0; s < 8; s++) begin
      seq = make_sequence($urandom_range(3, 6));
      send_sequence(seq);
    end
    wait_results_drained();

    // reversed run that fills the store and goes past it, ending on a dropped element
    gaps_on = 1'b0;
    seq.delete();
    for (int i = 0; i < MaxItems + 3; i++) seq = {seq, ValMax - value_t'(i)};
    send_sequence(seq);

    first_random = items_sent;
    while (items_sent - first_random < RandomItems) begin
      gaps_on = (items_sent - first_random < RandomItems - QuietTail) &&
                ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(1, 12);
      else if (pick < 95) len = $urandom_range(13, 40);
      else                len = $urandom_range(41, 100);
      seq = make_sequence(len);
      send_sequence(seq);
      if (gaps_on && $urandom_range(0, 9) == 0) begin
        wait_results_drained();
        idle_input($urandom_range(1, 17));
      end
    end

    gaps_on = 1'b0;
    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (tally.failures == 0 && tally.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ic_pkg.sv
rtl/ic_if.sv
rtl/ic_ram.sv
rtl/ic_merge.sv
rtl/inversion_counter_core.sv
tb/inversion_counter_core_tb.sv
